// File: rtl/ec_pof_pkg.sv
package ec_pof_pkg;

  localparam int ORDER_W = 17;
  localparam int OUT_W = ((ORDER_W + 7) / 8) * 8;
  localparam int CFG_IDX_W = 1;
  localparam int MOD_RESET = 19;

  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_A = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 1'b1;

  typedef enum logic [15:0] {
    S_IDLE  = 16'b0000_0000_0000_0001,
    S_AMOD  = 16'b0000_0000_0000_0010,
    S_ADD   = 16'b0000_0000_0000_0100,
    S_SQX   = 16'b0000_0000_0000_1000,
    S_TRI1  = 16'b0000_0000_0001_0000,
    S_TRI2  = 16'b0000_0000_0010_0000,
    S_TRI3  = 16'b0000_0000_0100_0000,
    S_INV   = 16'b0000_0000_1000_0000,
    S_EDIV  = 16'b0000_0001_0000_0000,
    S_LAM   = 16'b0000_0010_0000_0000,
    S_MLAM  = 16'b0000_0100_0000_0000,
    S_MLAM2 = 16'b0000_1000_0000_0000,
    S_XR2   = 16'b0001_0000_0000_0000,
    S_YR0   = 16'b0010_0000_0000_0000,
    S_MY    = 16'b0100_0000_0000_0000,
    S_DONE  = 16'b1000_0000_0000_0000
  } state_t;

endpackage

// File: rtl/ec_point_order_finder.sv
// A bad coordinate goes straight to the result. Otherwise a is first reduced modulo the
// modulus, then the point is added to the base again and again, each addition inverting by
// Euclid steps (a doubling first squares x and forms 3x^2 + a), for up to modulus + 1
// additions, and the result is then presented. One word is processed at a time through one
// shared shift-and-add multiplier and restoring divider; the next word is taken only after that.
// Reset is synchronous: curve_a clears, modulus returns to 19, the output empties.
module ec_point_order_finder #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [ec_pof_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [COORD_WIDTH-1:0]                cfg_data,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // base_x, base_y
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // point_order
  output logic [ec_pof_pkg::OUT_W-1:0]          m_axis_tdata,
  // found, bad_input
  output logic [1:0]                            m_axis_tuser
);
  import ec_pof_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int BW = $clog2(CW);

  function automatic logic [CW-1:0] mod_add(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                            input logic [CW-1:0] m);
    logic [CW:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] mod_sub(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                            input logic [CW-1:0] m);
    logic [CW:0] s;
    if (x >= y) s = {1'b0, x} - {1'b0, y};
    else        s = {1'b0, x} + {1'b0, m} - {1'b0, y};
    return s[CW-1:0];
  endfunction

  state_t state;
  logic [CW-1:0] curve_a, modulus, a_red;
  logic [CW-1:0] gx, gy, wx, wy, num, den, lam, xr;
  logic [CW:0]   cnt;
  logic [CW-1:0] r0, r1, t0, t1, acc, rem, dq;
  logic [CW-1:0] mq, mb, mres;
  logic [BW-1:0] bitc;
  logic [ORDER_W-1:0] res_order, o_order;
  logic res_found, res_bad, o_valid, o_found, o_bad;

  logic [CW-1:0] base_x, base_y, div_den, rem_next, acc_next, mul_next, inv_v;
  logic [CW:0]   rem_sh, cnt_inc;
  logic          div_ge, step_last;

  assign base_x = s_axis_tdata[CW-1:0];
  assign base_y = s_axis_tdata[2*CW-1:CW];

  always_comb begin
    div_den   = (state == S_AMOD) ? modulus : r1;
    rem_sh    = {rem, dq[CW-1]};
    div_ge    = rem_sh >= {1'b0, div_den};
    rem_next  = div_ge ? CW'(rem_sh - {1'b0, div_den}) : rem_sh[CW-1:0];
    acc_next  = mod_add(mod_add(acc, acc, modulus), div_ge ? t1 : '0, modulus);
    mul_next  = mod_add(mod_add(mres, mres, modulus), mq[CW-1] ? mb : '0, modulus);
    step_last = bitc == BW'(CW - 1);
    cnt_inc   = cnt + 1'b1;
    inv_v     = (r0 == CW'(1) && modulus != CW'(1)) ? t0 : '0;
  end

  assign s_axis_tready = state == S_IDLE;
  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = OUT_W'(o_order);
  assign m_axis_tuser  = {o_bad, o_found};

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      curve_a <= '0;
      modulus <= CW'(MOD_RESET);
      o_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_CURVE_A) curve_a <= cfg_data;
        if (cfg_index == CFG_MODULUS) modulus <= cfg_data;
      end
      if (o_valid && m_axis_tready && state != S_DONE) o_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            gx   <= base_x;
            gy   <= base_y;
            wx   <= base_x;
            wy   <= base_y;
            cnt  <= (CW+1)'(1);
            dq   <= curve_a;
            rem  <= '0;
            bitc <= '0;
            if (base_x >= modulus || base_y >= modulus) begin
              res_order <= '0;
              res_found <= 1'b0;
              res_bad   <= 1'b1;
              state     <= S_DONE;
            end else begin
              state <= S_AMOD;
            end
          end
        end
        S_AMOD: begin
          rem  <= rem_next;
          dq   <= dq << 1;
          bitc <= bitc + 1'b1;
          if (step_last) begin
            a_red <= rem_next;
            state <= S_ADD;
          end
        end
        S_ADD: begin
          if (wx == gx) begin
            if (mod_add(wy, gy, modulus) == '0 || wy != gy) begin
              res_order <= ORDER_W'(cnt_inc);
              res_found <= 1'b1;
              res_bad   <= 1'b0;
              state     <= S_DONE;
            end else begin
              den   <= mod_add(wy, wy, modulus);
              mq    <= wx;
              mb    <= wx;
              mres  <= '0;
              bitc  <= '0;
              state <= S_SQX;
            end
          end else begin
            num   <= mod_sub(gy, wy, modulus);
            den   <= mod_sub(gx, wx, modulus);
            state <= S_INV;
          end
        end
        S_SQX: begin
          mres <= mul_next;
          mq   <= mq << 1;
          bitc <= bitc + 1'b1;
          if (step_last) begin
            num   <= mul_next;
            state <= S_TRI1;
          end
        end
        S_TRI1: begin
          xr    <= mod_add(num, num, modulus);
          state <= S_TRI2;
        end
        S_TRI2: begin
          xr    <= mod_add(xr, num, modulus);
          state <= S_TRI3;
        end
        S_TRI3: begin
          num   <= mod_add(xr, a_red, modulus);
          state <= S_INV;
        end
        S_INV: begin
          r0   <= modulus;
          r1   <= den;
          t0   <= '0;
          t1   <= CW'(1);
          dq   <= modulus;
          rem  <= '0;
          acc  <= '0;
          bitc <= '0;
          state <= (den == '0) ? S_LAM : S_EDIV;
        end
        S_EDIV: begin
          if (step_last) begin
            r0   <= r1;
            r1   <= rem_next;
            t0   <= t1;
            t1   <= mod_sub(t0, acc_next, modulus);
            dq   <= r1;
            rem  <= '0;
            acc  <= '0;
            bitc <= '0;
            if (rem_next == '0) state <= S_LAM;
          end else begin
            rem  <= rem_next;
            acc  <= acc_next;
            dq   <= dq << 1;
            bitc <= bitc + 1'b1;
          end
        end
        S_LAM: begin
          mq    <= num;
          mb    <= inv_v;
          mres  <= '0;
          bitc  <= '0;
          state <= S_MLAM;
        end
        S_MLAM: begin
          if (step_last) begin
            lam   <= mul_next;
            mq    <= mul_next;
            mb    <= mul_next;
            mres  <= '0;
            bitc  <= '0;
            state <= S_MLAM2;
          end else begin
            mres <= mul_next;
            mq   <= mq << 1;
            bitc <= bitc + 1'b1;
          end
        end
        S_MLAM2: begin
          mres <= mul_next;
          mq   <= mq << 1;
          bitc <= bitc + 1'b1;
          if (step_last) begin
            xr    <= mod_sub(mul_next, wx, modulus);
            state <= S_XR2;
          end
        end
        S_XR2: begin
          xr    <= mod_sub(xr, gx, modulus);
          state <= S_YR0;
        end
        S_YR0: begin
          mq    <= lam;
          mb    <= mod_sub(wx, xr, modulus);
          mres  <= '0;
          bitc  <= '0;
          state <= S_MY;
        end
        S_MY: begin
          mres <= mul_next;
          mq   <= mq << 1;
          bitc <= bitc + 1'b1;
          if (step_last) begin
            wy  <= mod_sub(mul_next, wy, modulus);
            wx  <= xr;
            cnt <= cnt_inc;
            if (cnt_inc > ({1'b0, modulus} + 1'b1)) begin
              res_order <= ORDER_W'(cnt_inc);
              res_found <= 1'b0;
              res_bad   <= 1'b0;
              state     <= S_DONE;
            end else begin
              state <= S_ADD;
            end
          end
        end
        S_DONE: begin
          if (!o_valid || m_axis_tready) begin
            o_valid <= 1'b1;
            o_order <= res_order;
            o_found <= res_found;
            o_bad   <= res_bad;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/ec_pof_chk.sv
module ec_pof_chk #(
  parameter int COORD_WIDTH = 16
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [ec_pof_pkg::OUT_W-1:0]        m_axis_tdata,
  input logic [1:0]                          m_axis_tuser
);
  import ec_pof_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a point is in work");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("found and bad_input both set");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[ORDER_W-1:0] == '0)
    else $error("bad input with nonzero order");

endmodule

bind ec_point_order_finder ec_pof_chk #(.COORD_WIDTH(COORD_WIDTH)) u_chk (
  .clk(clk),
  .rst(rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata),
  .m_axis_tuser(m_axis_tuser)
);

// File: sim/ec_point_order_finder_tb.sv
module ec_point_order_finder_tb;

  import ec_pof_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int LONG_HOLD = 600;

  typedef struct packed {
    logic [16:0] order;
    logic        found;
    logic        bad;
  } order_word_t;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [15:0]          val;
    logic [15:0]          x;
    logic [15:0]          y;
    bit                   known;
    order_word_t          want;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic [1:0]           m_axis_tuser;

  order_word_t order_q[$];
  logic [15:0] cur_a;
  logic [15:0] cur_p;
  int          errors = 0;
  int          received = 0;
  int          quiet_cycles = 0;
  bit          no_gaps = 1'b0;
  stim_row_t   rows[$];

  ec_point_order_finder #(.COORD_WIDTH(16)) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint mod_inverse(longint u, longint m);
    longint r0, r1, t0, t1, q, tmp;
    r0 = m;
    r1 = u % m;
    t0 = 0;
    t1 = 1;
    while (r1 != 0) begin
      q = r0 / r1;
      tmp = r0 - q * r1;
      r0 = r1;
      r1 = tmp;
      tmp = t0 - q * t1;
      t0 = t1;
      t1 = tmp;
    end
    if (r0 != 1 || m == 1) return 0;
    if (t0 < 0) t0 += m;
    return t0 % m;
  endfunction

  function automatic order_word_t point_order(logic [15:0] bx, logic [15:0] by);
    order_word_t res;
    longint p, a, gx, gy, wx, wy, lam, nx, cnt;
    bit at_inf;
    p = cur_p;
    gx = bx;
    gy = by;
    res = '0;
    if (gx >= p || gy >= p) begin
      res.bad = 1'b1;
      return res;
    end
    a = cur_a % p;
    wx = gx;
    wy = gy;
    cnt = 1;
    forever begin
      at_inf = 1'b0;
      if (wx == gx && (wy + gy) % p == 0) begin
        at_inf = 1'b1;
      end else if (wx == gx && wy == gy) begin
        lam = ((3 * ((wx * wx) % p) + a) % p * mod_inverse((2 * wy) % p, p)) % p;
      end else if ((gx + p - wx) % p == 0) begin
        at_inf = 1'b1;
      end else begin
        lam = (((gy + p - wy) % p) * mod_inverse((gx + p - wx) % p, p)) % p;
      end
      cnt++;
      if (at_inf) begin
        res.order = cnt[16:0];
        res.found = 1'b1;
        return res;
      end
      nx = ((lam * lam) % p + 2 * p - wx - gx) % p;
      wy = ((lam * ((wx + p - nx) % p)) % p + p - wy) % p;
      wx = nx;
      if (cnt > p + 1) begin
        res.order = cnt[16:0];
        return res;
      end
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch in word %0d: %s got %0d, expected %0d", received, what, got, want);
    errors++;
  endtask

  task automatic drain_and_settle();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    while (order_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CURVE_A) cur_a = val;
    else cur_p = val;
    @(posedge clk);
  endtask

  task automatic send_point(logic [15:0] bx, logic [15:0] by, bit known, order_word_t want);
    int gap;
    order_word_t pred;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pred = point_order(bx, by);
    if (known && pred != want) begin
      $display("table row for (%0d,%0d) disagrees with prediction", bx, by);
      errors++;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {by, bx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    order_q.push_back(known ? want : pred);
  endtask

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic stim_row_t pt_row(logic [15:0] x, logic [15:0] y, bit known = 0,
                                       logic [16:0] ord = 0, bit fnd = 0, bit bad = 0);
    stim_row_t r;
    r = '{default: '0};
    r.x = x;
    r.y = y;
    r.known = known;
    r.want = '{order: ord, found: fnd, bad: bad};
    return r;
  endfunction

  always begin
    int hold;
    while (rst) @(posedge clk);
    if (received == 30) hold = LONG_HOLD;
    else hold = no_gaps ? 0 : $urandom_range(0, 9);
    if (hold > 0) begin
      m_axis_tready <= 1'b0;
      repeat (hold) @(posedge clk);
    end
    m_axis_tready <= 1'b1;
    @(posedge clk);
    while (!m_axis_tvalid) @(posedge clk);
    if (order_q.size() == 0) begin
      report_mismatch("unexpected word, order", m_axis_tdata[16:0], 0);
    end else begin
      order_word_t w;
      w = order_q.pop_front();
      if (m_axis_tdata[16:0] !== w.order) report_mismatch("point_order", m_axis_tdata[16:0], w.order);
      if (m_axis_tuser[0] !== w.found) report_mismatch("found", m_axis_tuser[0], w.found);
      if (m_axis_tuser[1] !== w.bad) report_mismatch("bad_input", m_axis_tuser[1], w.bad);
    end
    received++;
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[ec_point_order_finder] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int plist[$];
    int n;
    logic [15:0] x, y;
    plist = '{3, 5, 7, 9, 11, 13, 15, 17, 19, 21, 23, 25, 29, 31, 37, 41, 43, 47, 53};
    cur_a = 16'd0;
    cur_p = 16'(MOD_RESET);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rows.push_back(pt_row(16'd0, 16'd0, 1, 17'd2, 1, 0));
    rows.push_back(pt_row(16'd19, 16'd0, 1, 17'd0, 0, 1));
    rows.push_back(pt_row(16'd0, 16'd19, 1, 17'd0, 0, 1));
    rows.push_back(pt_row(16'hFFFF, 16'hFFFF, 1, 17'd0, 0, 1));
    rows.push_back(pt_row(16'd18, 16'd18));
    rows.push_back(pt_row(16'd5, 16'd1));
    rows.push_back(pt_row(16'd3, 16'd0, 1, 17'd2, 1, 0));
    rows.push_back(cfg_row(CFG_CURVE_A, 16'd2));
    rows.push_back(pt_row(16'd7, 16'd11));
    rows.push_back(pt_row(16'd1, 16'd1));
    rows.push_back(cfg_row(CFG_CURVE_A, 16'hFFFF));
    rows.push_back(pt_row(16'd2, 16'd3));
    rows.push_back(cfg_row(CFG_MODULUS, 16'd3));
    rows.push_back(pt_row(16'd2, 16'd2));
    rows.push_back(pt_row(16'd3, 16'd0, 1, 17'd0, 0, 1));
    rows.push_back(cfg_row(CFG_MODULUS, 16'd15));
    rows.push_back(pt_row(16'd4, 16'd7));
    rows.push_back(pt_row(16'd14, 16'd14));
    rows.push_back(cfg_row(CFG_MODULUS, 16'd1));
    rows.push_back(pt_row(16'd0, 16'd0, 1, 17'd2, 1, 0));
    rows.push_back(pt_row(16'd0, 16'd1, 1, 17'd0, 0, 1));
    rows.push_back(cfg_row(CFG_MODULUS, 16'd0));
    rows.push_back(pt_row(16'd0, 16'd0, 1, 17'd0, 0, 1));
    rows.push_back(cfg_row(CFG_MODULUS, 16'hFFFF));
    rows.push_back(cfg_row(CFG_CURVE_A, 16'd0));
    rows.push_back(pt_row(16'hFFFE, 16'd0, 1, 17'd2, 1, 0));
    rows.push_back(pt_row(16'hAAAA, 16'd0, 1, 17'd2, 1, 0));
    rows.push_back(pt_row(16'hFFFF, 16'd0, 1, 17'd0, 0, 1));
    rows.push_back(pt_row(16'h5555, 16'hFFFF, 1, 17'd0, 0, 1));

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        drain_and_settle();
        write_reg(rows[i].idx, rows[i].val);
      end else begin
        send_point(rows[i].x, rows[i].y, rows[i].known, rows[i].want);
      end
    end

    n = 0;
    for (int ph = 0; ph < 8; ph++) begin
      drain_and_settle();
      write_reg(CFG_MODULUS, 16'(plist[$urandom_range(0, plist.size() - 1)]));
      case ($urandom_range(0, 3))
        0: write_reg(CFG_CURVE_A, 16'd0);
        1: write_reg(CFG_CURVE_A, 16'hFFFF);
        default: write_reg(CFG_CURVE_A, 16'($urandom()));
      endcase
      no_gaps = (ph == 3);
      for (int k = 0; k < 10; k++) begin
        if (ph == 5 && k == 6) begin
          s_axis_tvalid <= 1'b0;
          while (order_q.size() != 0) @(posedge clk);
        end
        if ($urandom_range(0, 9) < 8) begin
          x = 16'($urandom_range(0, cur_p - 1));
          y = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(0, cur_p - 1));
        end else begin
          x = 16'($urandom());
          y = 16'($urandom());
        end
        send_point(x, y, 0, '0);
        n++;
      end
    end
    no_gaps = 1'b0;

    s_axis_tvalid <= 1'b0;
    while (order_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("[ec_point_order_finder] OK");
    end else begin
      $display("[ec_point_order_finder] ERROR");
    end
    $finish;
  end

endmodule
